// ----- src/spvm_pkg.sv -----
// shared types and constants for the sample playback voice mixer
package spvm_pkg;

	localparam int VOICES       = 8;
	localparam int VOICE_W      = 3;
	localparam int ADDR_W       = 12;
	localparam int SAMPLE_DEPTH = 1 << ADDR_W;
	localparam int WORD_W       = 16;
	localparam int POS_W        = 13;
	localparam int RATIO_W      = 8;
	localparam int MASK_W       = 8;

	localparam logic [POS_W-1:0] POS_MAX = '1;
	localparam logic [VOICE_W-1:0] LAST_VOICE = VOICE_W'(VOICES - 1);

	// request opcodes
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_START = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;

	typedef struct packed {
		logic [1:0]         op;
		logic [ADDR_W-1:0]  address;
		logic [WORD_W-1:0]  sample_word;
		logic [POS_W-1:0]   sample_length;
		logic [RATIO_W-1:0] hold_ratio;
		logic               is_stereo;
	} req_t;

	typedef struct packed {
		logic [WORD_W-1:0]  left_out;
		logic [WORD_W-1:0]  right_out;
		logic [MASK_W-1:0]  finished_mask;
		logic [VOICE_W-1:0] start_slot;
		logic               start_ok;
	} rsp_t;

endpackage

// ----- src/sample_playback_voice_mixer_top.sv -----
// top level of the sample playback voice mixer: voice sequencer and mix accumulators
//
//  channel   signals               direction  handshake
//  request   start, busy, req      in         taken when start is high and busy is low
//  result    done, rsp             out        valid for the one cycle done is high
//
// a tick walks the voices one at a time through the single sample memory read port:
// a silent voice passes only the voice state, a mono voice the voice and left states,
// a stereo voice also the right state; the tick's result comes on the cycle busy falls.
// start, write and unused opcodes answer on the next cycle and never raise busy.
// reset clears the voice slots at once; sample memory has no reset and no clearing pass.
// the receiver cannot stall: each result shows for exactly one cycle.
module sample_playback_voice_mixer_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  spvm_pkg::req_t req,
	output logic           busy,
	output logic           done,
	output spvm_pkg::rsp_t rsp
);
	import spvm_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_VOICE = 4'b0010,
		S_LEFT  = 4'b0100,
		S_RIGHT = 4'b1000
	} state_t;

	state_t state_q, state_d;
	logic [VOICE_W-1:0] v_q, v_d;
	logic [WORD_W-1:0]  left_q, left_d, right_q, right_d;
	logic [MASK_W-1:0]  mask_q, mask_d;
	logic [ADDR_W-1:0]  addr_q, addr_d;
	rsp_t               rsp_q, rsp_d;
	logic               done_q, done_d;

	// voice slots
	logic [VOICES-1:0]  active_q;
	logic [ADDR_W-1:0]  base_q   [VOICES];
	logic [POS_W-1:0]   pos_q    [VOICES];
	logic [POS_W-1:0]   len_q    [VOICES];
	logic [RATIO_W-1:0] ratio_q  [VOICES];
	logic [RATIO_W-1:0] hold_q   [VOICES];
	logic [VOICES-1:0]  stereo_q;

	logic accept;
	logic free_found;
	logic [VOICE_W-1:0] free_idx;
	logic claim_en, upd_en, free_en, last_visit;

	logic               cur_active, cur_stereo, eligible;
	logic [POS_W-1:0]   cur_pos, cur_len, pos_new;
	logic [RATIO_W-1:0] hold_load, hold_next;
	logic [POS_W:0]     pos_sum;
	logic [ADDR_W-1:0]  voice_addr, rd_addr;
	logic [WORD_W-1:0]  rd_data;

	assign accept = start && !busy;
	assign busy   = (state_q != S_IDLE);
	assign done   = done_q;
	assign rsp    = rsp_q;

	// sample memory
	spvm_ram u_ram (
		.clk     (clk),
		.wr_en   (accept && (req.op == OP_WRITE)),
		.wr_addr (req.address),
		.wr_data (req.sample_word),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = VOICES - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_found = 1'b1;
				free_idx   = VOICE_W'(i);
			end
		end
	end

	// current voice view and its position update
	always_comb begin
		cur_active = active_q[v_q];
		cur_stereo = stereo_q[v_q];
		cur_pos    = pos_q[v_q];
		cur_len    = len_q[v_q];
		eligible   = cur_active && (cur_pos < cur_len);
		voice_addr = base_q[v_q] + cur_pos[ADDR_W-1:0];
		if (hold_q[v_q] == '0) begin
			hold_load = (ratio_q[v_q] == '0) ? RATIO_W'(1) : ratio_q[v_q];
		end else begin
			hold_load = hold_q[v_q];
		end
		hold_next = hold_load - RATIO_W'(1);
		pos_sum   = {1'b0, cur_pos} + (cur_stereo ? (POS_W+1)'(2) : (POS_W+1)'(1));
		if (hold_next != '0) begin
			pos_new = cur_pos;
		end else if (pos_sum[POS_W]) begin
			pos_new = POS_MAX;
		end else begin
			pos_new = pos_sum[POS_W-1:0];
		end
		rd_addr = (state_q == S_LEFT) ? (addr_q + ADDR_W'(1)) : voice_addr;
	end

	// sequencer
	always_comb begin
		state_d    = state_q;
		v_d        = v_q;
		left_d     = left_q;
		right_d    = right_q;
		mask_d     = mask_q;
		addr_d     = addr_q;
		rsp_d      = rsp_q;
		done_d     = 1'b0;
		claim_en   = 1'b0;
		upd_en     = 1'b0;
		free_en    = 1'b0;
		last_visit = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					rsp_d = '0;
					if (req.op == OP_TICK) begin
						state_d = S_VOICE;
						v_d     = '0;
						left_d  = '0;
						right_d = '0;
						mask_d  = '0;
					end else if (req.op == OP_START) begin
						claim_en = free_found;
						rsp_d.start_slot = free_found ? free_idx : '0;
						rsp_d.start_ok   = free_found;
						done_d = 1'b1;
					end else begin
						done_d = 1'b1;
					end
				end
			end
			S_VOICE: begin
				if (eligible) begin
					addr_d  = voice_addr;
					state_d = S_LEFT;
				end else begin
					// an active voice already at its end is freed here
					free_en = cur_active;
					if (cur_active) begin
						mask_d[v_q] = 1'b1;
					end
					last_visit = 1'b1;
				end
			end
			S_LEFT: begin
				left_d = left_q + rd_data;
				if (cur_stereo) begin
					state_d = S_RIGHT;
				end else begin
					right_d = right_q + rd_data;
					upd_en  = 1'b1;
				end
			end
			S_RIGHT: begin
				right_d = right_q + rd_data;
				upd_en  = 1'b1;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
		// advance position, free on reaching the end
		if (upd_en) begin
			if (pos_new >= cur_len) begin
				free_en     = 1'b1;
				mask_d[v_q] = 1'b1;
			end
			last_visit = 1'b1;
		end
		// move on to next voice or finish the frame
		if (last_visit) begin
			if (v_q == LAST_VOICE) begin
				state_d = S_IDLE;
				done_d  = 1'b1;
				rsp_d   = '0;
				rsp_d.left_out      = left_d;
				rsp_d.right_out     = right_d;
				rsp_d.finished_mask = mask_d;
			end else begin
				v_d     = v_q + VOICE_W'(1);
				state_d = S_VOICE;
			end
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			v_q      <= '0;
			left_q   <= '0;
			right_q  <= '0;
			mask_q   <= '0;
			addr_q   <= '0;
			rsp_q    <= '0;
			done_q   <= 1'b0;
			active_q <= '0;
		end else begin
			state_q <= state_d;
			v_q     <= v_d;
			left_q  <= left_d;
			right_q <= right_d;
			mask_q  <= mask_d;
			addr_q  <= addr_d;
			rsp_q   <= rsp_d;
			done_q  <= done_d;
			if (claim_en) begin
				active_q[free_idx] <= 1'b1;
			end
			if (free_en) begin
				active_q[v_q] <= 1'b0;
			end
		end
	end

	// voice slot payload
	always_ff @(posedge clk) begin
		if (claim_en) begin
			base_q[free_idx]   <= req.address;
			len_q[free_idx]    <= req.sample_length;
			ratio_q[free_idx]  <= req.hold_ratio;
			stereo_q[free_idx] <= req.is_stereo;
			pos_q[free_idx]    <= '0;
			hold_q[free_idx]   <= '0;
		end
		if (upd_en) begin
			hold_q[v_q] <= hold_next;
			pos_q[v_q]  <= pos_new;
		end
	end

	// a result is only shown once the sequencer is back at rest
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy)
		else $error("result strobe while sequencer busy");

	// a granted slot is held by the new voice
	a_slot_taken: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && rsp_q.start_ok) |-> active_q[rsp_q.start_slot])
		else $error("granted slot not active");

	// reported voices have been freed
	a_finished_freed: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ((rsp_q.finished_mask & MASK_W'(active_q)) == '0))
		else $error("finished voice still active");

endmodule

// ----- src/spvm_ram.sv -----
// sample word memory, one write port and one registered read port
module spvm_ram (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [spvm_pkg::ADDR_W-1:0] wr_addr,
	input  logic [spvm_pkg::WORD_W-1:0] wr_data,
	input  logic [spvm_pkg::ADDR_W-1:0] rd_addr,
	output logic [spvm_pkg::WORD_W-1:0] rd_data
);
	import spvm_pkg::*;

	logic [WORD_W-1:0] mem_q [SAMPLE_DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data <= mem_q[rd_addr];
	end

endmodule
